// File: hdl/merging_address_range_table_macros.svh
// Assertion macros used by the checker file.
`ifndef MERGING_ADDRESS_RANGE_TABLE_MACROS_SVH
`define MERGING_ADDRESS_RANGE_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define MART_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mart assertion failed");

// Next-cycle implication.
`define MART_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mart assertion failed");

`endif

// File: hdl/mart_pkg.sv
// Package: sizes, mode codes and controller/datapath link types.
`timescale 1ns / 1ps

package mart_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_BITS   = 32;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
        logic emit;
    } mart_cmd_t;

    typedef struct packed {
        logic scan_done;
    } mart_stat_t;

endpackage

// File: hdl/mart_in_if.sv
// Input item channel: mode and operands.
`timescale 1ns / 1ps

interface mart_in_if;
    import mart_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [ADDR_BITS-1:0] range_low;
    logic [ADDR_BITS-1:0] range_high;
    logic [ADDR_BITS-1:0] lookup_address;

    modport source (output valid, output mode, output range_low, output range_high,
                    output lookup_address, input ready);
    modport sink   (input valid, input mode, input range_low, input range_high,
                    input lookup_address, output ready);
endinterface

// File: hdl/mart_out_if.sv
// Result channel: hit, overflow and entry count.
`timescale 1ns / 1ps

interface mart_out_if;
    import mart_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic                overflow;
    logic [CNT_BITS-1:0] entry_count;

    modport source (output valid, output hit, output overflow, output entry_count,
                    input ready);
    modport sink   (input valid, input hit, input overflow, input entry_count,
                    output ready);
endinterface

// File: hdl/merging_address_range_table.sv
// Top level: merging address range table.
`timescale 1ns / 1ps

// Sorted, disjoint table of up to TABLE_DEPTH inclusive address ranges.
// Insert (mode 0) folds the new range into every stored range it overlaps or
// abuts; lookup (mode 1) reports whether an address is covered; clear
// (mode 2) empties the table. Each beat on in_item gives exactly one beat on
// result. Items are handled one at a time: the scan reads one stored entry
// per cycle, and reads the first entry above an inserted range twice, once
// to place the new range ahead of it. A result may wait in its output
// register while the next item is accepted and worked on. Clear, unused
// mode 3 and reversed inserts do no scan. An insert that needs a new entry
// while the table is full leaves the table untouched and returns overflow.
module merging_address_range_table (
    input  logic clk,
    input  logic rst_n,
    mart_in_if.sink    in_item,
    mart_out_if.source result
);
    import mart_pkg::*;

    mart_cmd_t  cmd;
    mart_stat_t stat;

    mart_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_ready  (in_item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mart_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .mode           (in_item.mode),
        .range_low      (in_item.range_low),
        .range_high     (in_item.range_high),
        .lookup_address (in_item.lookup_address),
        .hit            (result.hit),
        .overflow       (result.overflow),
        .entry_count    (result.entry_count)
    );

endmodule

// File: hdl/mart_ctrl.sv
// Sequencer: accept, scan the table, commit, hand over the result.
`timescale 1ns / 1ps

module mart_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output mart_pkg::mart_cmd_t cmd,
    input  mart_pkg::mart_stat_t stat
);
    import mart_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = ~stat.scan_done;
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // the result register frees when empty or taken this cycle
                cmd.emit = ~out_valid_reg | out_ready;
                if (cmd.emit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hdl/mart_dp.sv
// Datapath: two banks of range registers, scan/merge unit, result registers.
`timescale 1ns / 1ps

module mart_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mart_pkg::mart_cmd_t            cmd,
    output mart_pkg::mart_stat_t           stat,
    input  logic [1:0]                     mode,
    input  logic [mart_pkg::ADDR_BITS-1:0] range_low,
    input  logic [mart_pkg::ADDR_BITS-1:0] range_high,
    input  logic [mart_pkg::ADDR_BITS-1:0] lookup_address,
    output logic                           hit,
    output logic                           overflow,
    output logic [mart_pkg::CNT_BITS-1:0]  entry_count
);
    import mart_pkg::*;

    // Bank bank_reg holds the live table; an insert pass rewrites it into the other.
    logic [ADDR_BITS-1:0] start_mem [2][TABLE_DEPTH];
    logic [ADDR_BITS-1:0] end_mem   [2][TABLE_DEPTH];

    logic                 bank_reg;
    logic [CNT_BITS-1:0]  used_reg;
    logic [CNT_BITS-1:0]  idx_reg;
    logic [CNT_BITS-1:0]  wr_cnt_reg;
    logic [ADDR_BITS-1:0] lo_reg;
    logic [ADDR_BITS-1:0] hi_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] nlo_reg;
    logic [ADDR_BITS-1:0] nhi_reg;
    logic                 ins_reg;
    logic                 lk_reg;
    logic                 clr_reg;
    logic                 merged_reg;
    logic                 placed_reg;
    logic                 hit_reg;
    logic                 res_hit_reg;
    logic                 res_ovf_reg;
    logic [CNT_BITS-1:0]  res_cnt_reg;
    logic                 out_hit_reg;
    logic                 out_ovf_reg;
    logic [CNT_BITS-1:0]  out_cnt_reg;

    logic [ADDR_BITS-1:0] rd_start;
    logic [ADDR_BITS-1:0] rd_end;
    logic                 below;
    logic                 above;
    logic                 inside_rng;
    logic                 full_drop;
    logic [CNT_BITS-1:0]  commit_cnt;
    logic [CNT_BITS-1:0]  wr_cnt_inc;

    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_idx;
    logic [ADDR_BITS-1:0] wr_start;
    logic [ADDR_BITS-1:0] wr_end;

    assign rd_start = start_mem[bank_reg][idx_reg[IDX_BITS-1:0]];
    assign rd_end   = end_mem[bank_reg][idx_reg[IDX_BITS-1:0]];

    // Touching counts as overlap; one extra bit keeps end+1 from wrapping.
    assign below      = ({1'b0, rd_end} + 1'b1) < {1'b0, lo_reg};
    assign above      = {1'b0, rd_start} > ({1'b0, hi_reg} + 1'b1);
    assign inside_rng = (rd_start <= addr_reg) && (addr_reg <= rd_end);

    assign full_drop  = ~merged_reg && (used_reg >= CNT_BITS'(TABLE_DEPTH));
    assign wr_cnt_inc = wr_cnt_reg + CNT_BITS'(1);
    assign commit_cnt = placed_reg ? wr_cnt_reg : wr_cnt_inc;

    assign stat.scan_done = ~(ins_reg | lk_reg) || (idx_reg >= used_reg);

    always_comb
    begin
        wr_en    = 1'b0;
        wr_idx   = wr_cnt_reg[IDX_BITS-1:0];
        wr_start = rd_start;
        wr_end   = rd_end;
        if (cmd.scan && ins_reg)
        begin
            if (below)
            begin
                wr_en = 1'b1;
            end
            else if (above)
            begin
                wr_en = 1'b1;
                if (!placed_reg)
                begin
                    wr_start = nlo_reg;
                    wr_end   = nhi_reg;
                end
            end
        end
        else if (cmd.finish && ins_reg && !full_drop && !placed_reg)
        begin
            wr_en    = 1'b1;
            wr_start = nlo_reg;
            wr_end   = nhi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[~bank_reg][wr_idx] <= wr_start;
            end_mem[~bank_reg][wr_idx]   <= wr_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= 1'b0;
            used_reg <= '0;
        end
        else if (cmd.finish)
        begin
            if (ins_reg && !full_drop)
            begin
                bank_reg <= ~bank_reg;
                used_reg <= commit_cnt;
            end
            else if (clr_reg)
            begin
                used_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg     <= range_low;
            hi_reg     <= range_high;
            addr_reg   <= lookup_address;
            nlo_reg    <= range_low;
            nhi_reg    <= range_high;
            ins_reg    <= (mode == MODE_INSERT) && (range_high >= range_low);
            lk_reg     <= (mode == MODE_LOOKUP);
            clr_reg    <= (mode == MODE_CLEAR);
            idx_reg    <= '0;
            wr_cnt_reg <= '0;
            merged_reg <= 1'b0;
            placed_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (lk_reg)
            begin
                hit_reg <= hit_reg | inside_rng;
                idx_reg <= idx_reg + CNT_BITS'(1);
            end
            else if (below)
            begin
                wr_cnt_reg <= wr_cnt_inc;
                idx_reg    <= idx_reg + CNT_BITS'(1);
            end
            else if (above)
            begin
                wr_cnt_reg <= wr_cnt_inc;
                // new range goes first; the same entry is copied next beat
                if (!placed_reg)
                begin
                    placed_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + CNT_BITS'(1);
                end
            end
            else
            begin
                merged_reg <= 1'b1;
                nlo_reg    <= (rd_start < nlo_reg) ? rd_start : nlo_reg;
                nhi_reg    <= (rd_end > nhi_reg) ? rd_end : nhi_reg;
                idx_reg    <= idx_reg + CNT_BITS'(1);
            end
        end

        if (cmd.finish)
        begin
            res_hit_reg <= lk_reg & hit_reg;
            res_ovf_reg <= ins_reg & full_drop;
            if (ins_reg && !full_drop)
            begin
                res_cnt_reg <= commit_cnt;
            end
            else if (clr_reg)
            begin
                res_cnt_reg <= '0;
            end
            else
            begin
                res_cnt_reg <= used_reg;
            end
        end

        if (cmd.emit)
        begin
            out_hit_reg <= res_hit_reg;
            out_ovf_reg <= res_ovf_reg;
            out_cnt_reg <= res_cnt_reg;
        end
    end

    assign hit         = out_hit_reg;
    assign overflow    = out_ovf_reg;
    assign entry_count = out_cnt_reg;

endmodule

// File: hdl/mart_checker.sv
// Port-level checker for the range table, bound to the top level.
`timescale 1ns / 1ps
`include "merging_address_range_table_macros.svh"

module mart_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          hit,
    input logic                          overflow,
    input logic [mart_pkg::CNT_BITS-1:0] entry_count
);
    import mart_pkg::*;

    `MART_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)
    `MART_ASSERT_NOW(a_hit_not_ovf, out_valid, !(hit && overflow))
    `MART_ASSERT_NOW(a_ovf_full, out_valid && overflow, entry_count == CNT_BITS'(TABLE_DEPTH))
    `MART_ASSERT_NOW(a_hit_nonempty, out_valid && hit, entry_count != '0)

endmodule

bind merging_address_range_table mart_checker u_mart_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .hit         (result.hit),
    .overflow    (result.overflow),
    .entry_count (result.entry_count)
);

// File: tb/sv/merging_address_range_table_tb.sv
// Testbench for merging_address_range_table: table predictor with checked results.
`timescale 1ns / 1ps

module merging_address_range_table_tb;
    import mart_pkg::*;

    typedef logic [ADDR_BITS-1:0] addr_t;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam addr_t      ADDR_TOP    = '1;
    localparam int         ITEM_TARGET = 900;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         TAIL_CYCLES = 40;

    typedef struct {
        logic [1:0] mode;
        addr_t      lo;
        addr_t      hi;
        addr_t      probe;
        bit         hold_for_drain;
    } table_op_t;

    typedef struct packed {
        logic                hit;
        logic                overflow;
        logic [CNT_BITS-1:0] entry_count;
    } range_reply_t;

    logic clk;
    logic rst_n;

    mart_in_if  in_bus ();
    mart_out_if res_bus ();

    merging_address_range_table i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_bus),
        .result  (res_bus)
    );

    // predicted table contents
    addr_t span_lo [TABLE_DEPTH];
    addr_t span_hi [TABLE_DEPTH];
    int    spans_held;

    table_op_t    op_queue [$];
    range_reply_t reply_queue [$];

    int  items_queued;
    int  items_accepted;
    int  replies_seen;
    int  mismatches;
    int  quiet_cycles;
    bit  in_taken;
    int  send_idle_pct;
    int  recv_stall_pct;

    always #5 clk = ~clk;

    function automatic range_reply_t fold_item(logic [1:0] mode, addr_t lo, addr_t hi,
                                               addr_t probe);
        range_reply_t reply;
        addr_t        next_lo [TABLE_DEPTH+1];
        addr_t        next_hi [TABLE_DEPTH+1];
        addr_t        new_lo;
        addr_t        new_hi;
        int           kept;
        bit           merged;
        bit           placed;
        reply  = '0;
        new_lo = lo;
        new_hi = hi;
        kept   = 0;
        merged = 1'b0;
        placed = 1'b0;
        case (mode)
            MODE_INSERT:
            begin
                if (hi >= lo)
                begin
                    for (int i = 0; i < spans_held; i++)
                    begin
                        if (lo != '0 && span_hi[i] < lo - 1)
                        begin
                            next_lo[kept] = span_lo[i];
                            next_hi[kept] = span_hi[i];
                            kept++;
                        end
                        else if (hi != ADDR_TOP && span_lo[i] > hi + 1)
                        begin
                            if (!placed)
                            begin
                                next_lo[kept] = new_lo;
                                next_hi[kept] = new_hi;
                                kept++;
                                placed = 1'b1;
                            end
                            next_lo[kept] = span_lo[i];
                            next_hi[kept] = span_hi[i];
                            kept++;
                        end
                        else
                        begin
                            // overlaps or abuts: fold into the new span
                            merged = 1'b1;
                            if (span_lo[i] < new_lo)
                                new_lo = span_lo[i];
                            if (span_hi[i] > new_hi)
                                new_hi = span_hi[i];
                        end
                    end
                    if (!merged && spans_held >= TABLE_DEPTH)
                        reply.overflow = 1'b1;
                    else
                    begin
                        if (!placed)
                        begin
                            next_lo[kept] = new_lo;
                            next_hi[kept] = new_hi;
                            kept++;
                        end
                        for (int i = 0; i < kept; i++)
                        begin
                            span_lo[i] = next_lo[i];
                            span_hi[i] = next_hi[i];
                        end
                        spans_held = kept;
                    end
                end
            end
            MODE_LOOKUP:
            begin
                for (int i = 0; i < spans_held; i++)
                    if (span_lo[i] <= probe && probe <= span_hi[i])
                        reply.hit = 1'b1;
            end
            MODE_CLEAR:
                spans_held = 0;
            default:
                ;
        endcase
        reply.entry_count = spans_held[CNT_BITS-1:0];
        return reply;
    endfunction

    task automatic queue_op(logic [1:0] mode, addr_t lo, addr_t hi, addr_t probe,
                            bit hold_for_drain);
        table_op_t op;
        op.mode           = mode;
        op.lo             = lo;
        op.hi             = hi;
        op.probe          = probe;
        op.hold_for_drain = hold_for_drain;
        op_queue = {op_queue, op};
        items_queued++;
    endtask

    // idling profile follows progress through the run
    always_comb
    begin
        case ((items_accepted / 75) % 4)
            1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
            3:       begin send_idle_pct = 19; recv_stall_pct = 19; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    end

    // input beats: predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_bus.valid && in_bus.ready;
            if (in_bus.valid && in_bus.ready)
            begin
                reply_queue.insert(reply_queue.size(),
                                   fold_item(in_bus.mode, in_bus.range_low,
                                             in_bus.range_high, in_bus.lookup_address));
                items_accepted++;
            end
        end
    end

    always @(negedge clk)
    begin : drive_items
        table_op_t next_op;
        if (rst_n)
        begin
            if (!in_bus.valid || in_taken)
            begin
                if (op_queue.size() != 0
                    && !(op_queue[0].hold_for_drain && reply_queue.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_op = op_queue.pop_front();
                    in_bus.valid          <= 1'b1;
                    in_bus.mode           <= next_op.mode;
                    in_bus.range_low      <= next_op.lo;
                    in_bus.range_high     <= next_op.hi;
                    in_bus.lookup_address <= next_op.probe;
                end
                else
                    in_bus.valid <= 1'b0;
            end
            res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        range_reply_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            replies_seen++;
            if (reply_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat %0d with nothing outstanding: hit=%0b ovf=%0b cnt=%0d",
                             replies_seen, res_bus.hit, res_bus.overflow, res_bus.entry_count);
            end
            else
            begin
                want = reply_queue.pop_front();
                if (res_bus.hit !== want.hit || res_bus.overflow !== want.overflow
                    || res_bus.entry_count !== want.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: exp hit/ovf/cnt %0b/%0b/%0d got %0b/%0b/%0d",
                                 replies_seen, want.hit, want.overflow, want.entry_count,
                                 res_bus.hit, res_bus.overflow, res_bus.entry_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", quiet_cycles);
                $display("CHECK FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        addr_t base;
        addr_t lo;
        addr_t hi;
        int    pick;
        int    burst;
        int    slot;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.mode           = MODE_INSERT;
        in_bus.range_low      = '0;
        in_bus.range_high     = '0;
        in_bus.lookup_address = '0;
        res_bus.ready         = 1'b0;
        in_taken              = 1'b0;
        spans_held            = 0;
        items_queued          = 0;
        items_accepted        = 0;
        replies_seen          = 0;
        mismatches            = 0;
        quiet_cycles          = 0;

        // directed: address extremes, abutting merges, reversed range, spare mode, clear
        queue_op(MODE_LOOKUP, ADDR_TOP, '0, '0, 1'b0);
        queue_op(MODE_INSERT, '0, '0, ADDR_TOP, 1'b0);
        queue_op(MODE_LOOKUP, '0, '0, '0, 1'b0);
        queue_op(MODE_INSERT, ADDR_TOP, ADDR_TOP, '0, 1'b0);
        queue_op(MODE_LOOKUP, '0, '0, ADDR_TOP, 1'b0);
        queue_op(MODE_LOOKUP, '0, '0, ADDR_TOP - 1, 1'b0);
        queue_op(MODE_INSERT, 32'd10, 32'd5, '0, 1'b0);
        queue_op(MODE_INSERT, 32'd2, 32'd3, '0, 1'b0);
        queue_op(MODE_INSERT, 32'd1, 32'd1, '0, 1'b0);
        queue_op(MODE_INSERT, 32'd5, 32'd9, '0, 1'b0);
        queue_op(MODE_INSERT, 32'd11, 32'd20, '0, 1'b0);
        queue_op(MODE_INSERT, 32'd10, 32'd10, '0, 1'b0);
        queue_op(MODE_INSERT, 32'd4, 32'd4, '0, 1'b0);
        queue_op(MODE_LOOKUP, '0, '0, 32'd21, 1'b0);
        queue_op(MODE_LOOKUP, '0, '0, 32'd20, 1'b0);
        queue_op(MODE_INSERT, ADDR_TOP - 5, ADDR_TOP - 1, '0, 1'b1);
        queue_op(MODE_UNUSED, ADDR_TOP, ADDR_TOP, ADDR_TOP, 1'b0);
        queue_op(MODE_INSERT, '0, ADDR_TOP, '0, 1'b0);
        queue_op(MODE_LOOKUP, '0, '0, 32'h8000_0000, 1'b0);
        queue_op(MODE_CLEAR, ADDR_TOP, '0, ADDR_TOP, 1'b0);
        queue_op(MODE_LOOKUP, '0, '0, 32'd5, 1'b0);
        queue_op(MODE_INSERT, ADDR_TOP - 1, ADDR_TOP, '0, 1'b0);
        queue_op(MODE_INSERT, '0, ADDR_TOP - 2, '0, 1'b0);
        queue_op(MODE_CLEAR, '0, '0, '0, 1'b1);

        // random bursts in a 128-address window of 4-address slots, so spans
        // abut, merge and fill the table
        while (items_queued < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                base = '0;
            else if (pick == 1)
                base = ADDR_TOP - 127;
            else
                base = addr_t'($urandom_range(0, 32'h01FF_FFFE)) << 7;
            burst = $urandom_range(30, 60);
            if ($urandom_range(0, 1) == 0)
                queue_op(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 2) == 0);
            for (int n = 0; n < burst; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    slot = $urandom_range(0, 31);
                    lo   = base + addr_t'(slot * 4 + $urandom_range(0, 1));
                    hi   = lo + addr_t'($urandom_range(0, 2));
                    queue_op(MODE_INSERT, lo, hi, $urandom, 1'b0);
                end
                else if (pick < 58)
                begin
                    lo = base + addr_t'($urandom_range(0, 127));
                    hi = lo + addr_t'($urandom_range(0, 40));
                    queue_op(MODE_INSERT, lo, hi, $urandom, 1'b0);
                end
                else if (pick < 62)
                begin
                    hi = $urandom_range(0, 32'hFFFF_FFFE);
                    lo = hi + addr_t'($urandom_range(1, 32'h7FFF_FFFF));
                    if (lo <= hi)
                        lo = ADDR_TOP;
                    queue_op(MODE_INSERT, lo, hi, $urandom, 1'b0);
                end
                else if (pick < 66)
                    queue_op(MODE_INSERT, $urandom, $urandom, $urandom, 1'b0);
                else if (pick < 88)
                    queue_op(MODE_LOOKUP, $urandom, $urandom,
                             base + addr_t'($urandom_range(0, 131)), 1'b0);
                else if (pick < 93)
                    queue_op(MODE_LOOKUP, $urandom, $urandom, $urandom, 1'b0);
                else if (pick < 96)
                    queue_op(MODE_UNUSED, $urandom, $urandom, $urandom, 1'b0);
                else
                    queue_op(MODE_CLEAR, $urandom, $urandom, $urandom, 1'b0);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_accepted < items_queued)
            @(negedge clk);
        while (reply_queue.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && reply_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: merging_address_range_table.f
+incdir+hdl
hdl/mart_pkg.sv
hdl/mart_in_if.sv
hdl/mart_out_if.sv
hdl/mart_ctrl.sv
hdl/mart_dp.sv
hdl/merging_address_range_table.sv
hdl/mart_checker.sv
tb/sv/merging_address_range_table_tb.sv
